>>> hw/rtl/ictf_pkg.sv
`default_nettype none
package ictf_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int INTERVAL_BITS = 20;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_N      = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int DT_W          = (INTERVAL_BITS < 20) ? INTERVAL_BITS : 20;
    localparam logic [19:0] DT_MASK = 20'((64'(1) << DT_W) - 64'(1));

    localparam int SQRT_STEPS = 15;
    // (4*p + 500000) / 1000000 == ((p + 125000) >> 4) / 15625
    localparam logic [35:0] DIV_HALF    = 36'd125000;
    // ceil(2^45 / 15625), exact for every numerator below 2^32
    localparam logic [31:0] RECIP_MUL   = 32'd2251799814;
    localparam int          RECIP_SHIFT = 45;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic [16:0] WEIGHT_RESET = 17'd64225;
    localparam logic [14:0] ONE_G_RESET  = 15'd4096;
    localparam logic signed [25:0] QUARTER_TURN = 26'sd5898240;
    localparam logic signed [26:0] ANGLE_MAX = 27'sd524287;
    localparam logic signed [26:0] ANGLE_MIN = -27'sd524288;

    localparam logic CFG_BLEND_WEIGHT = 1'b0;
    localparam logic CFG_ONE_G_COUNTS = 1'b1;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x_rate;
        logic signed [15:0] gyro_y_rate;
        logic        [19:0] interval_us;
    } in_t;

    typedef struct packed {
        logic signed [19:0] pitch_out;
        logic signed [19:0] roll_out;
    } out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_GG,
        OP_MUL_AA,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_CR_INIT,
        OP_CR_STEP,
        OP_CR_DONE,
        OP_DIV_MUL,
        OP_DIV_INIT,
        OP_DIV_RCP,
        OP_DIV_DONE,
        OP_BL_MUL1,
        OP_BL_MUL2,
        OP_BL_SUM
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       sel;   // 0 pitch, 1 roll
        logic [4:0] idx;
        logic       emit;
    } cmd_t;

    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:  v = 22'd2949120;
            5'd1:  v = 22'd1740967;
            5'd2:  v = 22'd919879;
            5'd3:  v = 22'd466945;
            5'd4:  v = 22'd234379;
            5'd5:  v = 22'd117304;
            5'd6:  v = 22'd58666;
            5'd7:  v = 22'd29335;
            5'd8:  v = 22'd14668;
            5'd9:  v = 22'd7334;
            5'd10: v = 22'd3667;
            5'd11: v = 22'd1833;
            5'd12: v = 22'd917;
            5'd13: v = 22'd458;
            5'd14: v = 22'd229;
            5'd15: v = 22'd115;
            5'd16: v = 22'd57;
            5'd17: v = 22'd29;
            5'd18: v = 22'd14;
            5'd19: v = 22'd7;
            5'd20: v = 22'd4;
            5'd21: v = 22'd2;
            5'd22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/imu_complementary_tilt_filter_top.sv
`default_nettype none
// channel   signals                         width / type
// input     in_valid, in_ready, in_data     ictf_pkg::in_t
// output    out_valid, out_ready, out_data  ictf_pkg::out_t
// config    cfg_we, cfg_index, cfg_data     1 bit index, 17 bit data
//
// after its accept, a result is built in 15 square root steps,
// two 16 step cordic passes and two reciprocal divides, which share one
// datapath; a new sample is accepted only once the previous one is done.
// a result waits in the output register; the next sample is taken meanwhile,
// and only its final write stalls until the previous beat is taken.
// reset clears pitch, roll and the registers to their defaults.
module imu_complementary_tilt_filter_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ictf_pkg::in_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ictf_pkg::out_t       out_data,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [16:0]     cfg_data
);
    import ictf_pkg::*;

    cmd_t cmd;

    ictf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ictf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

>>> hw/rtl/ictf_ctrl.sv
`default_nettype none
module ictf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output ictf_pkg::cmd_t     cmd
);
    import ictf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_GG, S_MUL_AA, S_SQ_INIT, S_SQ_STEP, S_CR_INIT, S_CR_STEP,
        S_CR_DONE, S_DIV_MUL, S_DIV_INIT, S_DIV_RCP, S_DIV_DONE, S_BL_MUL1,
        S_BL_MUL2, S_BL_SUM, S_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic       sel_reg, sel_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.op   = OP_NONE;
        cmd.sel  = sel_reg;
        cmd.idx  = cnt_reg;
        cmd.emit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MUL_GG;
                end
            end
            S_MUL_GG:
            begin
                cmd.op     = OP_MUL_GG;
                state_next = S_MUL_AA;
            end
            S_MUL_AA:
            begin
                cmd.op     = OP_MUL_AA;
                state_next = S_SQ_INIT;
            end
            S_SQ_INIT:
            begin
                cmd.op     = OP_SQ_INIT;
                cnt_next   = '0;
                state_next = S_SQ_STEP;
            end
            S_SQ_STEP:
            begin
                cmd.op   = OP_SQ_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    sel_next   = 1'b0;
                    state_next = S_CR_INIT;
                end
            end
            S_CR_INIT:
            begin
                cmd.op     = OP_CR_INIT;
                cnt_next   = '0;
                state_next = S_CR_STEP;
            end
            S_CR_STEP:
            begin
                cmd.op   = OP_CR_STEP;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_N - 1))
                    state_next = S_CR_DONE;
            end
            S_CR_DONE:
            begin
                cmd.op   = OP_CR_DONE;
                sel_next = ~sel_reg;
                state_next = sel_reg ? S_DIV_MUL : S_CR_INIT;
            end
            S_DIV_MUL:
            begin
                cmd.op     = OP_DIV_MUL;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                state_next = S_DIV_RCP;
            end
            S_DIV_RCP:
            begin
                cmd.op     = OP_DIV_RCP;
                state_next = S_DIV_DONE;
            end
            S_DIV_DONE:
            begin
                cmd.op     = OP_DIV_DONE;
                sel_next   = ~sel_reg;
                state_next = sel_reg ? S_BL_MUL1 : S_DIV_MUL;
            end
            S_BL_MUL1:
            begin
                cmd.op     = OP_BL_MUL1;
                state_next = S_BL_MUL2;
            end
            S_BL_MUL2:
            begin
                cmd.op     = OP_BL_MUL2;
                state_next = S_BL_SUM;
            end
            S_BL_SUM:
            begin
                cmd.op     = OP_BL_SUM;
                sel_next   = ~sel_reg;
                state_next = sel_reg ? S_FINISH : S_BL_MUL1;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ictf_datapath.sv
`default_nettype none
module ictf_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [16:0]   cfg_data,
    input  wire ictf_pkg::in_t in_data,
    input  wire ictf_pkg::cmd_t cmd,
    output ictf_pkg::out_t     out_data
);
    import ictf_pkg::*;

    logic [16:0] blend_weight_reg;
    logic [14:0] one_g_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic        [19:0] dt_reg;
    logic        [14:0] g_reg;
    logic        [16:0] w_reg;
    logic signed [42:0] prod_reg;
    logic        [29:0] gg_reg;
    logic        [30:0] sqn_reg, sqr_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [25:0] cz_reg;
    logic               czero_reg;
    logic signed [17:0] apitch_reg, aroll_reg;
    logic        [31:0] num_reg;
    logic        [17:0] q_reg;
    logic signed [21:0] gp_pitch_reg, gp_roll_reg;
    logic signed [42:0] sum_reg;
    logic signed [19:0] pitch_reg, roll_reg;
    out_t               out_reg;

    logic signed [21:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [16:0] ax_in, g_s;
    logic        [14:0] g_eff;
    logic        [16:0] w_eff;
    logic signed [15:0] g_rate;
    logic        [16:0] g_mag;
    logic signed [17:0] acc_sel;
    logic signed [21:0] gp_sel;
    logic signed [33:0] ix, iy, ix_r, iy_r;
    logic signed [25:0] iz;
    logic signed [33:0] dx, dy;
    logic signed [25:0] tz;
    logic        [30:0] sq_bit, sq_try;
    logic        [4:0]  sq_sh;
    logic        [63:0] rcp_full;
    logic signed [42:0] bl_sum;
    logic signed [26:0] bl_r;
    logic signed [19:0] bl_sat, st_sel;
    logic signed [25:0] z_rnd;
    logic signed [21:0] q_s;

    assign out_data = out_reg;

    always_comb
    begin
        g_eff  = (one_g_reg == 15'd0) ? 15'd1 : one_g_reg;
        w_eff  = (blend_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : blend_weight_reg;
        g_s    = $signed({2'b00, g_eff});
        ax_in  = 17'(in_data.accel_x);
        g_rate = cmd.sel ? gy_reg : gx_reg;
        g_mag  = g_rate[15] ? 17'(-18'(g_rate)) : 17'(g_rate);
        acc_sel = cmd.sel ? aroll_reg : apitch_reg;
        gp_sel  = cmd.sel ? gp_roll_reg : gp_pitch_reg;
        st_sel  = cmd.sel ? roll_reg : pitch_reg;

        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_GG:
            begin
                mul_a = 22'($signed({1'b0, g_reg}));
                mul_b = 21'($signed({1'b0, g_reg}));
            end
            OP_MUL_AA:
            begin
                mul_a = 22'(ax_reg);
                mul_b = 21'(ax_reg);
            end
            OP_DIV_MUL:
            begin
                mul_a = 22'($signed({1'b0, dt_reg}));
                mul_b = 21'($signed(g_mag));
            end
            OP_BL_MUL1:
            begin
                mul_a = gp_sel;
                mul_b = 21'($signed({1'b0, w_reg}));
            end
            OP_BL_MUL2:
            begin
                mul_a = 22'(acc_sel);
                mul_b = 21'($signed({1'b0, WEIGHT_ONE - w_reg}));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // cordic seed with quadrant pre-rotation
        if (cmd.sel)
        begin
            ix = 34'(az_reg) <<< 14;
            iy = 34'(ay_reg) <<< 14;
        end
        else
        begin
            ix = 34'(sqr_reg[14:0]) <<< 14;
            iy = 34'(ax_reg) <<< 14;
        end
        ix_r = ix;
        iy_r = iy;
        iz   = '0;
        if (ix < 0)
        begin
            if (iy >= 0)
            begin
                ix_r = iy;
                iy_r = -ix;
                iz   = QUARTER_TURN;
            end
            else
            begin
                ix_r = -iy;
                iy_r = ix;
                iz   = -QUARTER_TURN;
            end
        end

        dx = cy_reg >>> cmd.idx;
        dy = cx_reg >>> cmd.idx;
        tz = 26'($signed({1'b0, atan_entry(cmd.idx)}));
        z_rnd = (cz_reg + 26'sd128) >>> 8;

        sq_sh  = 5'd28 - {cmd.idx[3:0], 1'b0};
        sq_bit = 31'(1) << sq_sh;
        sq_try = sqr_reg + sq_bit;

        // divide by 15625 as a reciprocal multiply
        rcp_full = 64'(num_reg) * 64'(RECIP_MUL);

        q_s = $signed({4'b0000, q_reg});

        bl_sum = sum_reg + prod_reg + 43'sd32768;
        bl_r   = 27'(bl_sum >>> 16);
        if (bl_r > ANGLE_MAX)
            bl_sat = 20'(ANGLE_MAX);
        else if (bl_r < ANGLE_MIN)
            bl_sat = 20'(ANGLE_MIN);
        else
            bl_sat = bl_r[19:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_weight_reg <= WEIGHT_RESET;
            one_g_reg        <= ONE_G_RESET;
            pitch_reg        <= '0;
            roll_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BLEND_WEIGHT: blend_weight_reg <= cfg_data;
                    CFG_ONE_G_COUNTS: one_g_reg        <= cfg_data[14:0];
                    default:          one_g_reg        <= one_g_reg;
                endcase
            end
            if (cmd.op == OP_BL_SUM)
            begin
                if (cmd.sel)
                    roll_reg <= bl_sat;
                else
                    pitch_reg <= bl_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.emit)
        begin
            out_reg.pitch_out <= pitch_reg;
            out_reg.roll_out  <= roll_reg;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                // clamp the asin argument to one g
                if (ax_in > g_s)
                    ax_reg <= g_s[15:0];
                else if (ax_in < -g_s)
                    ax_reg <= 16'(-g_s);
                else
                    ax_reg <= in_data.accel_x;
                ay_reg <= in_data.accel_y;
                az_reg <= in_data.accel_z;
                gx_reg <= in_data.gyro_x_rate;
                gy_reg <= in_data.gyro_y_rate;
                dt_reg <= in_data.interval_us & DT_MASK;
                g_reg  <= g_eff;
                w_reg  <= w_eff;
            end
            OP_MUL_AA:
            begin
                gg_reg <= prod_reg[29:0];
            end
            OP_SQ_INIT:
            begin
                sqn_reg <= {1'b0, gg_reg - prod_reg[29:0]};
                sqr_reg <= '0;
            end
            OP_SQ_STEP:
            begin
                if (sqn_reg >= sq_try)
                begin
                    sqn_reg <= sqn_reg - sq_try;
                    sqr_reg <= (sqr_reg >> 1) + sq_bit;
                end
                else
                begin
                    sqr_reg <= sqr_reg >> 1;
                end
            end
            OP_CR_INIT:
            begin
                cx_reg    <= ix_r;
                cy_reg    <= iy_r;
                cz_reg    <= iz;
                czero_reg <= (ix == 0) && (iy == 0);
            end
            OP_CR_STEP:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + tz;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - tz;
                end
            end
            OP_CR_DONE:
            begin
                if (cmd.sel)
                    aroll_reg <= czero_reg ? 18'sd0 : z_rnd[17:0];
                else
                    apitch_reg <= czero_reg ? 18'sd0 : z_rnd[17:0];
            end
            OP_DIV_INIT:
            begin
                // rounding half and the factor of four folded into a shift by four
                num_reg <= 32'((prod_reg[35:0] + DIV_HALF) >> 4);
            end
            OP_DIV_RCP:
            begin
                q_reg <= rcp_full[RECIP_SHIFT +: 18];
            end
            OP_DIV_DONE:
            begin
                if (cmd.sel)
                    gp_roll_reg <= 22'(st_sel) + (g_rate[15] ? -q_s : q_s);
                else
                    gp_pitch_reg <= 22'(st_sel) + (g_rate[15] ? -q_s : q_s);
            end
            OP_BL_MUL2:
            begin
                sum_reg <= prod_reg;
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sim/imu_complementary_tilt_filter_top_tb.sv
`default_nettype none
module imu_complementary_tilt_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ictf_pkg::*;

    class tilt_scoreboard;
        longint weight;
        longint one_g;
        longint pitch_acc;
        longint roll_acc;
        out_t angle_q[$];
        int errors;
        int checked;

        function new();
            weight = 64225;
            one_g = 4096;
            pitch_acc = 0;
            roll_acc = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic idx, logic [16:0] val);
            if (idx == CFG_BLEND_WEIGHT)
                weight = longint'(val);
            else
                one_g = longint'(val[14:0]);
        endfunction

        function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint int_sqrt(longint n);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > n)
                b = b >>> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        endfunction

        function longint vector_angle(longint y, longint x);
            longint z;
            longint t;
            longint dx;
            longint dy;
            longint steps[24];
            steps = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                      14668, 7334, 3667, 1833, 917, 458, 229, 115,
                      57, 29, 14, 7, 4, 2, 1, 0};
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            x = x * 16384;
            y = y * 16384;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    t = x; x = y; y = -t; z = 90 * 65536;
                end
                else
                begin
                    t = x; x = -y; y = t; z = -90 * 65536;
                end
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx; y -= dy; z += steps[i];
                end
                else
                begin
                    x -= dx; y += dy; z -= steps[i];
                end
            end
            return (z + 128) >>> 8;
        endfunction

        function longint rate_step(longint rate, longint dt);
            longint mag;
            longint q;
            mag = rate < 0 ? -rate : rate;
            q = (mag * dt * 4 + 500000) / 1000000;
            return rate < 0 ? -q : q;
        endfunction

        function longint mix(longint gyro_path, longint acc, longint w);
            longint s;
            s = w * gyro_path + (65536 - w) * acc;
            s = (s + 32768) >>> 16;
            if (s > 524287) s = 524287;
            if (s < -524288) s = -524288;
            return s;
        endfunction

        function void note_sample(in_t d);
            longint w;
            longint g;
            longint ax;
            longint side;
            out_t o;
            w = weight > 65536 ? 65536 : weight;
            g = one_g == 0 ? 1 : one_g;
            ax = longint'(d.accel_x);
            if (ax > g) ax = g;
            if (ax < -g) ax = -g;
            side = int_sqrt(g * g - ax * ax);
            pitch_acc = mix(pitch_acc + rate_step(longint'(d.gyro_x_rate),
                                                  longint'(d.interval_us)),
                            vector_angle(ax, side), w);
            roll_acc = mix(roll_acc + rate_step(longint'(d.gyro_y_rate),
                                                longint'(d.interval_us)),
                           vector_angle(longint'(d.accel_y), longint'(d.accel_z)), w);
            o.pitch_out = pitch_acc[19:0];
            o.roll_out = roll_acc[19:0];
            angle_q.push_back(o);
        endfunction

        function void check_angles(out_t got);
            out_t exp_o;
            if (angle_q.size() == 0)
            begin
                $display("%0t unexpected beat pitch=%0d roll=%0d", $time,
                         got.pitch_out, got.roll_out);
                errors++;
                return;
            end
            exp_o = angle_q.pop_front();
            checked++;
            if (got.pitch_out !== exp_o.pitch_out)
            begin
                $display("%0t pitch mismatch expected %0d actual %0d", $time,
                         exp_o.pitch_out, got.pitch_out);
                errors++;
            end
            if (got.roll_out !== exp_o.roll_out)
            begin
                $display("%0t roll mismatch expected %0d actual %0d", $time,
                         exp_o.roll_out, got.roll_out);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 0;
    out_t out_data;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [16:0] cfg_data = '0;
    tilt_scoreboard sb;
    int sent;
    int stall_left = 0;

    imu_complementary_tilt_filter_top uut (.*);

    always #4 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    task automatic write_reg(logic idx, logic [16:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.angle_q.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // valid stays up across back to back beats
    task automatic send_sample(in_t d, bit pace);
        int gap;
        gap = pace ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_sample(d);
        sent++;
    endtask

    function automatic longint pick16();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? 32767 : -32768;
        if (r < 4) return $signed(16'($urandom));
        return longint'($urandom_range(0, 12000)) - 6000;
    endfunction

    function automatic in_t rand_sample();
        in_t d;
        int r;
        d.accel_x = 16'(pick16());
        d.accel_y = 16'(pick16());
        d.accel_z = 16'(pick16());
        d.gyro_x_rate = 16'(pick16());
        d.gyro_y_rate = 16'(pick16());
        r = $urandom_range(0, 9);
        if (r == 0) d.interval_us = 20'($urandom);
        else if (r == 1) d.interval_us = 20'd0;
        else d.interval_us = 20'($urandom_range(500, 20000));
        if ($urandom_range(0, 19) == 0)
        begin
            d.accel_y = '0;
            d.accel_z = '0;
        end
        return d;
    endfunction

    function automatic in_t mk(int ax, int ay, int az, int gx, int gy, int dt);
        in_t d;
        d.accel_x = 16'(ax);
        d.accel_y = 16'(ay);
        d.accel_z = 16'(az);
        d.gyro_x_rate = 16'(gx);
        d.gyro_y_rate = 16'(gy);
        d.interval_us = 20'(dt);
        return d;
    endfunction

    // output side: random stalls, now and then a long one, check each beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_angles(out_data);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 199) == 0)
            begin
                stall_left = $urandom_range(20, 150);
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 30) != 0);
        end
    end

    initial
    begin
        logic [16:0] weights[5];
        logic [16:0] gs[5];
        sb = new();
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: defaults, extremes, clamps, zero roll axes
        send_sample(mk(0, 0, 0, 0, 0, 0), 0);
        send_sample(mk(32767, 32767, 32767, 32767, 32767, 1048575), 0);
        send_sample(mk(-32768, -32768, -32768, -32768, -32768, 1048575), 0);
        send_sample(mk(4096, 0, 4096, 0, 0, 1000), 0);
        send_sample(mk(-4096, 100, -4096, 100, -100, 1000), 0);
        send_sample(mk(9000, -5, -3000, 2000, -2000, 250000), 0);
        send_sample(mk(-9000, 0, 0, -1, 1, 1), 0);
        send_sample(mk(2048, -4096, 0, 0, 0, 0), 1);
        send_sample(mk(100, 0, -1, 32767, -32768, 1048575), 1);
        drain();
        write_reg(CFG_BLEND_WEIGHT, 17'h1FFFF);
        write_reg(CFG_ONE_G_COUNTS, 17'd0);
        send_sample(mk(5, 3, -3, 32767, 32767, 1048575), 0);
        send_sample(mk(-5, -3, 3, 32767, 32767, 1048575), 0);
        send_sample(mk(0, 0, 0, 32767, 32767, 1048575), 0);
        send_sample(mk(1, -1, -1, -32768, -32768, 1048575), 0);
        drain();
        write_reg(CFG_BLEND_WEIGHT, 17'd0);
        write_reg(CFG_ONE_G_COUNTS, 17'd32767);
        send_sample(mk(32767, -32768, 1, 0, 0, 0), 0);
        send_sample(mk(-32768, 32767, -1, 5, 5, 10), 0);
        drain();
        weights = '{17'd65536, 17'd64225, 17'd0, 17'd32768, 17'd70000};
        gs = '{15'd4096, 15'd1, 15'd32767, 15'd1000, 15'd16384};
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_BLEND_WEIGHT, ph < 5 ? weights[ph] : 17'($urandom));
            write_reg(CFG_ONE_G_COUNTS, ph < 5 ? gs[ph] : 17'($urandom_range(0, 32767)));
            for (int k = 0; k < 143; k++)
            begin
                if (k == 70 && ph == 3)
                    drain();
                send_sample(rand_sample(), k > 30 || ph[0]);
            end
            drain();
        end
        $display("covered %0d samples, %0d results checked over 13 register settings",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.angle_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("timeout after %0d samples", sent);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
